// File: design/pidfd_pkg.sv
// Package: widths, payload structs, sequencer states and saturating helpers for the PID block.
`timescale 1ns / 1ps
`default_nettype none
package pidfd_pkg;
	localparam int DW = 32;
	localparam int FB = 16;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P     = 3'd0,
		REG_GAIN_I     = 3'd1,
		REG_GAIN_D     = 3'd2,
		REG_DRIVE_LOW  = 3'd3,
		REG_DRIVE_HIGH = 3'd4,
		REG_ACCUM_LOW  = 3'd5,
		REG_ACCUM_HIGH = 3'd6,
		REG_FILTER_TAU = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [DW-1:0] error_sample;
		logic        [DW-2:0] step_time;
	} in_item_t;

	typedef struct packed {
		logic signed [DW-1:0] drive;
		logic                 step_skipped;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIV_RAW, ST_DIV_ALPHA, ST_MUL_F, ST_ADD_F,
		ST_MUL_I1, ST_MUL_I2, ST_MUL_P, ST_MUL_D, ST_SUM, ST_FINISH
	} state_t;

	// saturating add of two signed words
	function automatic logic signed [DW-1:0] sat_add(logic signed [DW-1:0] a,
			logic signed [DW-1:0] b);
		logic signed [DW:0] s;
		s = {a[DW-1], a} + {b[DW-1], b};
		if (s[DW] != s[DW-1])
			return s[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
		return s[DW-1:0];
	endfunction

	function automatic logic signed [DW-1:0] sat_sub(logic signed [DW-1:0] a,
			logic signed [DW-1:0] b);
		logic signed [DW:0] s;
		s = {a[DW-1], a} - {b[DW-1], b};
		if (s[DW] != s[DW-1])
			return s[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
		return s[DW-1:0];
	endfunction

	// upper limit tested first, so with swapped limits a value above hi gives hi, else lo
	function automatic logic signed [DW-1:0] clampv(logic signed [DW-1:0] v,
			logic signed [DW-1:0] lo, logic signed [DW-1:0] hi);
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction
endpackage
`default_nettype wire

// File: design/pidfd_mul.sv
// Shared fixed-point multiplier: (a*b) >> FB, saturated, result registered.
`timescale 1ns / 1ps
`default_nettype none
module pidfd_mul (
	input  wire logic                            clk,
	input  wire logic signed [pidfd_pkg::DW-1:0] op_a,
	input  wire logic signed [pidfd_pkg::DW-1:0] op_b,
	output logic signed      [pidfd_pkg::DW-1:0] prod_q
);
	import pidfd_pkg::*;

	logic          neg;
	logic [DW-1:0] ma, mb;
	logic [2*DW-1:0] full, shifted, lim, msat;
	logic signed [DW-1:0] res;

	always_comb begin
		neg = op_a[DW-1] ^ op_b[DW-1];
		ma = op_a[DW-1] ? DW'(-op_a) : DW'(op_a);
		mb = op_b[DW-1] ? DW'(-op_b) : DW'(op_b);
		full = {{DW{1'b0}}, ma} * {{DW{1'b0}}, mb};
		shifted = full >> FB;
		lim = neg ? ((2*DW)'(1) << (DW-1)) : (((2*DW)'(1) << (DW-1)) - (2*DW)'(1));
		msat = (shifted > lim) ? lim : shifted;
		res = neg ? -msat[DW-1:0] : msat[DW-1:0];
	end

	always_ff @(posedge clk) begin
		prod_q <= res;
	end
endmodule
`default_nettype wire

// File: design/pidfd_div.sv
// Restoring bit-serial divider: (n << FB) / d, truncated toward zero, saturated.
`timescale 1ns / 1ps
`default_nettype none
module pidfd_div (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic signed [pidfd_pkg::DW-1:0] num,
	input  wire logic        [pidfd_pkg::DW-1:0] den,
	output logic                                 busy_q,
	output logic                                 done_q,
	output logic signed      [pidfd_pkg::DW-1:0] quot
);
	import pidfd_pkg::*;

	localparam int QW = DW + FB;
	localparam int CW = $clog2(QW + 1);

	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q, dsr_q;
	logic [QW-1:0] dvd_q, quo_q, lim, qsat;
	logic          neg_q;
	logic [DW:0]   trial;
	logic          fits;

	always_comb begin
		trial = {rem_q, dvd_q[QW-1]};
		fits = trial >= {1'b0, dsr_q};
		lim = neg_q ? (QW'(1) << (DW-1)) : ((QW'(1) << (DW-1)) - QW'(1));
		qsat = (quo_q > lim) ? lim : quo_q;
		quot = neg_q ? -qsat[DW-1:0] : qsat[DW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[DW-1];
			dvd_q <= {(num[DW-1] ? DW'(-num) : DW'(num)), {FB{1'b0}}};
			dsr_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= fits ? DW'(trial - {1'b0, dsr_q}) : trial[DW-1:0];
			quo_q <= {quo_q[QW-2:0], fits};
		end
	end
endmodule
`default_nettype wire

// File: design/pid_controller_filtered_derivative.sv
// Top level: PID controller with filtered derivative and integral anti-windup.
`timescale 1ns / 1ps
`default_nettype none
// PID controller in signed Q16.16. Each accepted transaction carries an error
// sample and a time step; one result transaction comes back per input. A zero
// time step returns drive 0 with step_skipped set and touches no state. An
// update runs on one bit-serial divider and one multiplier under a small
// sequencer. The raw-slope division develops 48 quotient bits and then signals
// done. The filter coefficient division runs only with a nonzero filter_tau,
// followed by the filter update, a multiply and an add. Then come the four
// remaining multiplies, the final sum and the result hand-off. The input
// side is stalled for the whole update. The finished result sits in an
// output register until taken; while an older result is still stalled there,
// the sequencer waits in its last state. A new transaction is accepted as
// soon as the sequencer is back in idle. Configuration is written through
// cfg_we, cfg_index and cfg_data; the user must write it only while no update
// is in flight, which the block itself does not enforce. All configuration
// registers reset to zero.
module pid_controller_filtered_derivative (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [pidfd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [pidfd_pkg::DW-1:0]             cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire pidfd_pkg::in_item_t                  in_item,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output pidfd_pkg::out_item_t                      out_item
);
	import pidfd_pkg::*;

	// configuration
	logic signed [DW-1:0] gp_q, gi_q, gd_q, dl_q, dh_q, al_q, ah_q;
	logic        [DW-2:0] tau_q;

	// controller state
	logic signed [DW-1:0] isum_q, last_q, fs_q;
	logic                 primed_q;

	// per-item work registers
	logic signed [DW-1:0] e_q, raw_q, alpha_q, icand_q, s1_q;
	logic        [DW-2:0] dt_q;
	logic                 skip_q;
	logic signed [DW-1:0] res_q;

	state_t state_q, state_d;

	logic signed [DW-1:0] mul_a, mul_b, prod_q;
	logic                 div_start, div_busy, div_done;
	logic signed [DW-1:0] div_num, div_q;
	logic        [DW-1:0] div_den;

	logic                 in_acc, out_free;
	logic signed [DW-1:0] total, clamped;
	logic                 commit;

	assign in_acc = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;
	assign in_stall = (state_q != ST_IDLE);

	pidfd_mul u_mul (
		.clk    (clk),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.prod_q (prod_q)
	);

	pidfd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy_q (div_busy),
		.done_q (div_done),
		.quot   (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gp_q <= '0; gi_q <= '0; gd_q <= '0;
			dl_q <= '0; dh_q <= '0; al_q <= '0; ah_q <= '0;
			tau_q <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_GAIN_P:     gp_q <= cfg_data;
				REG_GAIN_I:     gi_q <= cfg_data;
				REG_GAIN_D:     gd_q <= cfg_data;
				REG_DRIVE_LOW:  dl_q <= cfg_data;
				REG_DRIVE_HIGH: dh_q <= cfg_data;
				REG_ACCUM_LOW:  al_q <= cfg_data;
				REG_ACCUM_HIGH: ah_q <= cfg_data;
				REG_FILTER_TAU: tau_q <= cfg_data[DW-2:0];
				default: ;
			endcase
		end
	end

	// final sum and anti-windup decision
	always_comb begin
		total = sat_add(s1_q, prod_q);
		clamped = clampv(total, dl_q, dh_q);
		commit = (total == clamped) || (total > dh_q && e_q[DW-1])
			|| (total < dl_q && !e_q[DW-1] && e_q != '0);
	end

	// sequencer: next state, divider launch and multiplier operands
	always_comb begin
		state_d = state_q;
		div_start = 1'b0;
		div_num = sat_sub(in_item.error_sample,
			primed_q ? last_q : in_item.error_sample);
		div_den = {1'b0, in_item.step_time};
		mul_a = gi_q;
		mul_b = e_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (in_item.step_time == '0) begin
						state_d = ST_FINISH;
					end else begin
						div_start = 1'b1;
						state_d = ST_DIV_RAW;
					end
				end
			end
			ST_DIV_RAW: begin
				div_num = {1'b0, dt_q};
				div_den = DW'({1'b0, tau_q}) + DW'({1'b0, dt_q});
				if (div_done) begin
					if (tau_q != '0) begin
						div_start = 1'b1;
						state_d = ST_DIV_ALPHA;
					end else begin
						state_d = ST_MUL_I1;
					end
				end
			end
			ST_DIV_ALPHA: begin
				if (div_done)
					state_d = ST_MUL_F;
			end
			ST_MUL_F: begin
				mul_a = alpha_q;
				mul_b = sat_sub(raw_q, fs_q);
				state_d = ST_ADD_F;
			end
			ST_ADD_F:  state_d = ST_MUL_I1;
			ST_MUL_I1: begin
				mul_a = gi_q;
				mul_b = e_q;
				state_d = ST_MUL_I2;
			end
			ST_MUL_I2: begin
				mul_a = prod_q;
				mul_b = {1'b0, dt_q};
				state_d = ST_MUL_P;
			end
			ST_MUL_P: begin
				mul_a = gp_q;
				mul_b = e_q;
				state_d = ST_MUL_D;
			end
			ST_MUL_D: begin
				mul_a = gd_q;
				mul_b = fs_q;
				state_d = ST_SUM;
			end
			ST_SUM: state_d = ST_FINISH;
			ST_FINISH: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
			isum_q <= '0;
			last_q <= '0;
			fs_q <= '0;
			primed_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// a new result may replace one taken at the same edge
			if (state_q == ST_FINISH && out_free)
				out_valid <= 1'b1;
			else if (out_valid && !out_stall)
				out_valid <= 1'b0;
			case (state_q)
				ST_DIV_RAW: begin
					if (div_done && tau_q == '0)
						fs_q <= div_q;
				end
				ST_ADD_F: fs_q <= sat_add(fs_q, prod_q);
				ST_SUM: begin
					if (commit)
						isum_q <= icand_q;
					last_q <= e_q;
					primed_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			e_q <= in_item.error_sample;
			dt_q <= in_item.step_time;
			skip_q <= (in_item.step_time == '0);
			res_q <= '0;
		end
		if (state_q == ST_DIV_RAW && div_done)
			raw_q <= div_q;
		if (state_q == ST_DIV_ALPHA && div_done)
			alpha_q <= div_q;
		if (state_q == ST_MUL_P)
			icand_q <= clampv(sat_add(isum_q, prod_q), al_q, ah_q);
		if (state_q == ST_MUL_D)
			s1_q <= sat_add(prod_q, icand_q);
		if (state_q == ST_SUM)
			res_q <= clamped;
		if (state_q == ST_FINISH && out_free) begin
			out_item.drive <= res_q;
			out_item.step_skipped <= skip_q;
		end
	end

`ifndef SYNTH
	a_div_in_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> (state_q == ST_DIV_RAW || state_q == ST_DIV_ALPHA))
		else $error("divider busy outside a divide state");
	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_FINISH))
		else $error("result raised outside finish");
	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.step_skipped) |-> (out_item.drive == '0))
		else $error("skipped step with nonzero drive");
`endif
endmodule
`default_nettype wire
